// ===== sv/lpkj_pkg.sv =====
`timescale 1ns / 1ps
// Package for the lattice polymer kink-jump engine: field widths, coordinate and
// result types, command and status codes. No dependencies.
package lpkj_pkg;

	localparam int COORD_W          = 6;
	localparam int SITE_W           = 10;
	localparam int LEN_OUT_W        = 11;
	localparam int MOVES_W          = 32;
	localparam int BOX_SIDE_DEF     = 64;
	localparam int MAX_MONOMERS_DEF = 1024;

	typedef logic [COORD_W-1:0] coord_axis_t;

	typedef struct packed {
		coord_axis_t x;
		coord_axis_t y;
		coord_axis_t z;
	} coord_t;

	localparam int COORD_BITS = $bits(coord_t);

	// Outcome of the corner test on one interior monomer.
	typedef struct packed {
		logic   corner;
		coord_t tgt;
	} kink_t;

	typedef enum logic {
		CMD_APPEND = 1'b0,
		CMD_MOVE   = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		STAT_APPENDED    = 3'd0,
		STAT_MOVED       = 3'd1,
		STAT_OCCUPIED    = 3'd2,
		STAT_NOT_CORNER  = 3'd3,
		STAT_END         = 3'd4,
		STAT_REFUSED     = 3'd5
	} status_t;

endpackage

// ===== sv/lpkj_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No package dependencies.
module lpkj_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/lpkj_kink.sv =====
`timescale 1ns / 1ps
// Corner test and opposite-corner target for one monomer and its two neighbors.
// Depends on lpkj_pkg.
module lpkj_kink (
	input  lpkj_pkg::coord_t prev,
	input  lpkj_pkg::coord_t self_pos,
	input  lpkj_pkg::coord_t next,
	output lpkj_pkg::kink_t  res
);
	import lpkj_pkg::*;

	logic [2:0] dp;
	logic [2:0] dn;
	logic       dp_one;
	logic       dn_one;

	assign dp = {prev.x != self_pos.x, prev.y != self_pos.y, prev.z != self_pos.z};
	assign dn = {next.x != self_pos.x, next.y != self_pos.y, next.z != self_pos.z};

	// Exactly one axis differs on each side.
	assign dp_one = (dp != 3'b000) && ((dp & (dp - 3'd1)) == 3'b000);
	assign dn_one = (dn != 3'b000) && ((dn & (dn - 3'd1)) == 3'b000);

	always_comb begin
		res.corner = dp_one && dn_one && (dp != dn);
		res.tgt.x  = dp[2] ? prev.x : (dn[2] ? next.x : self_pos.x);
		res.tgt.y  = dp[1] ? prev.y : (dn[1] ? next.y : self_pos.y);
		res.tgt.z  = dp[0] ? prev.z : (dn[0] ? next.z : self_pos.z);
	end

endmodule

// ===== sv/lattice_polymer_kink_jump_top.sv =====
`timescale 1ns / 1ps
// Top level of the lattice polymer kink-jump engine: sequencer, chain table and
// occupancy map. Depends on lpkj_pkg, lpkj_ram and lpkj_kink.
//
// The block keeps one polymer chain on a periodic cubic lattice of BOX_SIDE sites
// per axis. Commands are taken with start while busy is low; each command yields
// exactly one result, shown for a single cycle with done high, and the receiver
// must take it in that cycle because the block has no way to hold it. After reset
// the occupancy map is swept to zero, one site per cycle, which keeps busy high
// until all BOX_SIDE**3 sites (262144 at the default size) are clear. After its
// transfer an append is busy in S_ACHK, a move in S_MPREV, S_MSELF, S_MNEXT and
// S_MDEC, plus S_MCOMMIT when the jump is taken; done follows in the next cycle,
// and a new command may be transferred in that same cycle. The move time is set
// by the single read port of the chain table, which fetches the previous, current
// and next monomer in turn, followed by the map read of the target site and two map
// writes on the single map write port. Commands are handled strictly one at a time,
// so a command never reads an entry that an earlier command is still writing.
// chain_length and accepted_moves always show the current totals, valid with done.
module lattice_polymer_kink_jump_top #(
	parameter int BOX_SIDE     = lpkj_pkg::BOX_SIDE_DEF,
	parameter int MAX_MONOMERS = lpkj_pkg::MAX_MONOMERS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic                               command,
	input  logic [lpkj_pkg::SITE_W-1:0]        site,
	input  logic [lpkj_pkg::COORD_W-1:0]       pos_x,
	input  logic [lpkj_pkg::COORD_W-1:0]       pos_y,
	input  logic [lpkj_pkg::COORD_W-1:0]       pos_z,
	output logic                               done,
	output logic [2:0]                         status,
	output logic [lpkj_pkg::SITE_W-1:0]        site_out,
	output logic [lpkj_pkg::COORD_W-1:0]       new_x,
	output logic [lpkj_pkg::COORD_W-1:0]       new_y,
	output logic [lpkj_pkg::COORD_W-1:0]       new_z,
	output logic [lpkj_pkg::LEN_OUT_W-1:0]     chain_length,
	output logic [lpkj_pkg::MOVES_W-1:0]       accepted_moves
);
	import lpkj_pkg::*;

	localparam int MAP_DEPTH = BOX_SIDE * BOX_SIDE * BOX_SIDE;
	localparam int MAP_AW    = $clog2(MAP_DEPTH);
	localparam int TAB_AW    = $clog2(MAX_MONOMERS);
	localparam int LEN_W     = $clog2(MAX_MONOMERS + 1);

	typedef enum logic [2:0] {
		S_CLEAR,   // sweeping the occupancy map after reset
		S_IDLE,
		S_ACHK,    // append: map bit of the new site is back
		S_MPREV,   // move: previous monomer is back
		S_MSELF,   // move: current monomer is back
		S_MNEXT,   // move: next monomer is back, target map read issued
		S_MDEC,    // move: target map bit is back, decide
		S_MCOMMIT  // move: free the old site, rewrite the chain entry
	} state_t;

	state_t                 state_q;
	logic [MAP_AW-1:0]      clr_q;
	logic [SITE_W-1:0]      site_q;
	coord_t                 pos_q;
	logic [LEN_W-1:0]       len_q;
	logic [MOVES_W-1:0]     moves_q;
	coord_t                 prev_q;
	coord_t                 self_q;
	kink_t                  kink_q;
	logic                   done_q;
	status_t                status_q;
	logic [SITE_W-1:0]      site_out_q;
	coord_t                 new_q;

	// Memory ports.
	logic                   map_we;
	logic [MAP_AW-1:0]      map_waddr;
	logic                   map_wdata;
	logic [MAP_AW-1:0]      map_raddr;
	logic                   map_rdata;
	logic                   tab_we;
	logic [TAB_AW-1:0]      tab_waddr;
	coord_t                 tab_wdata;
	logic [TAB_AW-1:0]      tab_raddr;
	coord_t                 tab_rdata;

	coord_t                 pos_in;
	kink_t                  kink;
	logic                   accept;
	logic                   out_box;
	logic                   app_ok;
	logic                   out_range;
	logic                   is_end;
	logic                   move_go;

	function automatic logic [MAP_AW-1:0] map_idx(input coord_t c);
		return MAP_AW'((MAP_AW'(c.x) * MAP_AW'(BOX_SIDE) + MAP_AW'(c.y)) * MAP_AW'(BOX_SIDE)
			+ MAP_AW'(c.z));
	endfunction

	lpkj_ram #(
		.WIDTH(1),
		.DEPTH(MAP_DEPTH)
	) u_map (
		.clk  (clk),
		.we   (map_we),
		.waddr(map_waddr),
		.wdata(map_wdata),
		.raddr(map_raddr),
		.rdata(map_rdata)
	);

	lpkj_ram #(
		.WIDTH(COORD_BITS),
		.DEPTH(MAX_MONOMERS)
	) u_chain (
		.clk  (clk),
		.we   (tab_we),
		.waddr(tab_waddr),
		.wdata(tab_wdata),
		.raddr(tab_raddr),
		.rdata(tab_rdata)
	);

	// Next monomer comes straight from the table read data.
	lpkj_kink u_kink (
		.prev    (prev_q),
		.self_pos(self_q),
		.next    (tab_rdata),
		.res     (kink)
	);

	assign pos_in = '{x: pos_x, y: pos_y, z: pos_z};
	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	// Append checks: full chain, coordinates outside the box, site already taken.
	assign out_box = (32'(pos_q.x) >= 32'(BOX_SIDE)) || (32'(pos_q.y) >= 32'(BOX_SIDE))
		|| (32'(pos_q.z) >= 32'(BOX_SIDE));
	assign app_ok  = (32'(len_q) < 32'(MAX_MONOMERS)) && !out_box && !map_rdata;

	// Move checks.
	assign out_range = 32'(site_q) >= 32'(len_q);
	assign is_end    = (site_q == '0) || ((32'(site_q) + 32'd1) == 32'(len_q));
	assign move_go   = !out_range && !is_end && kink_q.corner && !map_rdata;

	always_comb begin
		map_we    = 1'b0;
		map_waddr = map_idx(pos_q);
		map_wdata = 1'b1;
		map_raddr = map_idx(kink.tgt);
		tab_we    = 1'b0;
		tab_waddr = TAB_AW'(len_q);
		tab_wdata = pos_q;
		tab_raddr = TAB_AW'(site_q);
		case (state_q)
			S_CLEAR: begin
				map_we    = 1'b1;
				map_waddr = clr_q;
				map_wdata = 1'b0;
			end
			S_IDLE: begin
				map_raddr = map_idx(pos_in);
				tab_raddr = TAB_AW'({7'b0, site} - 17'd1);
			end
			S_ACHK: begin
				map_we = app_ok;
				tab_we = app_ok;
			end
			S_MSELF: begin
				tab_raddr = TAB_AW'({7'b0, site_q} + 17'd1);
			end
			S_MDEC: begin
				map_we    = move_go;
				map_waddr = map_idx(kink_q.tgt);
			end
			S_MCOMMIT: begin
				map_we    = 1'b1;
				map_waddr = map_idx(self_q);
				map_wdata = 1'b0;
				tab_we    = 1'b1;
				tab_waddr = TAB_AW'(site_q);
				tab_wdata = kink_q.tgt;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			site_q     <= '0;
			pos_q      <= '0;
			len_q      <= '0;
			moves_q    <= '0;
			prev_q     <= '0;
			self_q     <= '0;
			kink_q     <= '0;
			done_q     <= 1'b0;
			status_q   <= STAT_APPENDED;
			site_out_q <= '0;
			new_q      <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == MAP_AW'(MAP_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						site_q  <= site;
						pos_q   <= pos_in;
						state_q <= (cmd_t'(command) == CMD_APPEND) ? S_ACHK : S_MPREV;
					end
				end
				S_ACHK: begin
					done_q     <= 1'b1;
					site_out_q <= SITE_W'(len_q);
					state_q    <= S_IDLE;
					if (app_ok) begin
						len_q    <= len_q + 1'b1;
						status_q <= STAT_APPENDED;
						new_q    <= pos_q;
					end else begin
						status_q <= STAT_REFUSED;
						new_q    <= '0;
					end
				end
				S_MPREV: begin
					prev_q  <= tab_rdata;
					state_q <= S_MSELF;
				end
				S_MSELF: begin
					self_q  <= tab_rdata;
					state_q <= S_MNEXT;
				end
				S_MNEXT: begin
					kink_q  <= kink;
					state_q <= S_MDEC;
				end
				S_MDEC: begin
					site_out_q <= site_q;
					if (move_go) begin
						state_q <= S_MCOMMIT;
					end else begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
						new_q   <= self_q;
						if (out_range) begin
							status_q <= STAT_END;
							new_q    <= '0;
						end else if (is_end) begin
							status_q <= STAT_END;
						end else if (!kink_q.corner) begin
							status_q <= STAT_NOT_CORNER;
						end else begin
							status_q <= STAT_OCCUPIED;
						end
					end
				end
				S_MCOMMIT: begin
					done_q   <= 1'b1;
					moves_q  <= moves_q + 1'b1;
					status_q <= STAT_MOVED;
					new_q    <= kink_q.tgt;
					state_q  <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done           = done_q;
	assign status         = status_q;
	assign site_out       = site_out_q;
	assign new_x          = new_q.x;
	assign new_y          = new_q.y;
	assign new_z          = new_q.z;
	assign chain_length   = LEN_OUT_W'(len_q);
	assign accepted_moves = moves_q;

	// A result only ever closes a command that kept the block busy.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a preceding busy cycle");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(len_q) <= 32'(MAX_MONOMERS))
		else $error("chain length exceeds table depth");

	// A taken move bumps the move count exactly once.
	a_move_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status_q == STAT_MOVED) |-> (moves_q == $past(moves_q) + 1'b1))
		else $error("move count not advanced by a taken move");

	// The freed site and the newly taken site of a jump are never the same.
	a_jump_sites_differ: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MCOMMIT) |-> (map_waddr != $past(map_waddr)))
		else $error("kink jump writes one map site twice");

	a_no_result_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !done)
		else $error("result strobe during the map clearing pass");

endmodule
